### rtl/linear_probe_hash_table_defines.svh
// Assertion macros for the linear probing hash table.
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// same-cycle implication under clock and reset
`define LPH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hash table check failed");

// next-cycle implication under clock and reset
`define LPH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hash table check failed");

`endif

### rtl/lph_pkg.sv
// Shared types, constants and control store of the linear probing hash table.
`default_nettype none
package lph_pkg;

    localparam int SIZE_MAX = 255;
    localparam int MOD_BITS_PER_CYCLE = 8;
    localparam logic [1:0] MOD_LAST = 2'd3;
    localparam logic [7:0] SIZE_RESET = 8'd128;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        OUT_INSERTED  = 2'd0,
        OUT_FULL      = 2'd1,
        OUT_FOUND     = 2'd2,
        OUT_NOT_FOUND = 2'd3
    } t_outcome;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_MOD,
        ACT_FIX,
        ACT_READ,
        ACT_EVAL,
        ACT_EMIT
    } t_act;

    typedef enum logic [2:0] {
        CND_ALWAYS,
        CND_NO_INPUT,
        CND_MOD_BUSY,
        CND_PROBE_MORE,
        CND_OUT_BUSY
    } t_cond;

    typedef logic [2:0] t_step;

    localparam t_step STEP_IDLE = 3'd0;
    localparam t_step STEP_MOD  = 3'd1;
    localparam t_step STEP_FIX  = 3'd2;
    localparam t_step STEP_READ = 3'd3;
    localparam t_step STEP_EVAL = 3'd4;
    localparam t_step STEP_EMIT = 3'd5;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_step jmp_t;
        t_step jmp_f;
    } t_uop;

    typedef struct packed {
        logic in_valid;
        logic mod_busy;
        logic probe_more;
        logic out_busy;
    } t_status;

    function automatic t_uop uop_rom(input t_step s);
        t_uop u;
        case (s)
            STEP_IDLE: u = '{ACT_LOAD, CND_NO_INPUT,   STEP_IDLE, STEP_MOD};
            STEP_MOD:  u = '{ACT_MOD,  CND_MOD_BUSY,   STEP_MOD,  STEP_FIX};
            STEP_FIX:  u = '{ACT_FIX,  CND_ALWAYS,     STEP_READ, STEP_READ};
            STEP_READ: u = '{ACT_READ, CND_ALWAYS,     STEP_EVAL, STEP_EVAL};
            STEP_EVAL: u = '{ACT_EVAL, CND_PROBE_MORE, STEP_READ, STEP_EMIT};
            STEP_EMIT: u = '{ACT_EMIT, CND_OUT_BUSY,   STEP_EMIT, STEP_IDLE};
            default:   u = '{ACT_NONE, CND_ALWAYS,     STEP_IDLE, STEP_IDLE};
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

### rtl/linear_probe_hash_table.sv
// Top level of the linear probing hash table: datapath, handshakes and checks.
`default_nettype none
`include "linear_probe_hash_table_defines.svh"
// One request at a time: accept, then the signed modulo (four passes of eight bits),
// setup, the probes (each a registered slot read, then a compare) and the hand-over to
// the output register; a request makes from 1 to the table size probes. A new request
// is taken while the last result waits in the output register. Reset clears all
// occupied flags at once; keys need no clearing. A table size of 0 acts as 1 and one
// above the slot count acts as the slot count (at most 255).
module linear_probe_hash_table
    import lph_pkg::*;
#(
    parameter int TABLE_DEPTH = 128
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [7:0]  i_cfg_data,    // table_size
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,  // key[31:0]
    input  wire         s_axis_tuser,  // kind[0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // slot[6:0], zero[7]
    output logic [1:0]  m_axis_tuser   // outcome[1:0]
);

    localparam int SLOTS = (TABLE_DEPTH < SIZE_MAX) ? TABLE_DEPTH : SIZE_MAX;
    localparam int IW    = $clog2(SLOTS);

    t_act               act;
    t_status            status;
    logic        [7:0]  r_size;
    logic        [7:0]  size_eff;
    logic               r_kind;
    logic signed [31:0] r_key;
    logic        [7:0]  r_size_eff;
    logic        [IW-1:0] r_pos;
    logic        [IW-1:0] n_pos;
    logic        [7:0]  r_probes;
    logic        [7:0]  n_probes;
    t_outcome           r_res_outcome;
    t_outcome           n_res_outcome;
    logic        [6:0]  r_res_slot;
    logic        [6:0]  n_res_slot;
    logic               r_m_valid;
    t_outcome           r_m_outcome;
    logic        [6:0]  r_m_slot;
    logic               in_accept;
    logic               mod_busy;
    logic        [7:0]  mod_rem;
    logic               rd_used;
    logic        [31:0] rd_key;
    logic               st_rd;
    logic               st_wr;
    logic        [7:0]  pos8;
    logic        [8:0]  pos_inc;
    logic               exhausted;
    logic               done_hit;
    logic               emit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (i_cfg_valid) begin
            r_size <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_size == 8'd0) begin
            size_eff = 8'd1;
        end else if (int'(r_size) > SLOTS) begin
            size_eff = 8'(SLOTS);
        end else begin
            size_eff = r_size;
        end
    end

    lph_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_act    (act)
    );

    lph_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_accept),
        .i_key   (s_axis_tdata),
        .i_size  (size_eff),
        .o_busy  (mod_busy),
        .o_rem   (mod_rem)
    );

    lph_store #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (st_rd),
        .i_wr    (st_wr),
        .i_addr  (r_pos),
        .i_wkey  (r_key),
        .o_used  (rd_used),
        .o_key   (rd_key)
    );

    assign s_axis_tready = (act == ACT_LOAD);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb begin
        pos8      = 8'(r_pos);
        pos_inc   = {1'b0, pos8} + 9'd1;
        exhausted = ({1'b0, r_probes} + 9'd1) == {1'b0, r_size_eff};
        if (r_kind == KIND_INSERT) begin
            done_hit = !rd_used;
        end else begin
            done_hit = !rd_used || (rd_key == r_key);
        end

        n_pos         = r_pos;
        n_probes      = r_probes;
        n_res_outcome = r_res_outcome;
        n_res_slot    = r_res_slot;
        st_rd         = 1'b0;
        st_wr         = 1'b0;
        emit          = 1'b0;

        case (act)
            ACT_FIX: begin
                n_pos    = IW'(mod_rem);
                n_probes = '0;
            end
            ACT_READ: begin
                st_rd = 1'b1;
            end
            ACT_EVAL: begin
                if (r_kind == KIND_INSERT && !rd_used) begin
                    st_wr         = 1'b1;
                    n_res_outcome = OUT_INSERTED;
                    n_res_slot    = pos8[6:0];
                end else if (r_kind == KIND_SEARCH && !rd_used) begin
                    n_res_outcome = OUT_NOT_FOUND;
                    n_res_slot    = '0;
                end else if (r_kind == KIND_SEARCH && rd_key == r_key) begin
                    n_res_outcome = OUT_FOUND;
                    n_res_slot    = pos8[6:0];
                end else begin
                    n_res_outcome = (r_kind == KIND_INSERT) ? OUT_FULL : OUT_NOT_FOUND;
                    n_res_slot    = '0;
                    n_probes      = r_probes + 8'd1;
                    n_pos         = (pos_inc == {1'b0, r_size_eff}) ? '0 : IW'(pos_inc);
                end
            end
            ACT_EMIT: begin
                emit = !r_m_valid || m_axis_tready;
            end
            default: begin
            end
        endcase

        status.in_valid   = s_axis_tvalid;
        status.mod_busy   = mod_busy;
        status.probe_more = !done_hit && !exhausted;
        status.out_busy   = r_m_valid && !m_axis_tready;
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind     <= s_axis_tuser;
            r_key      <= s_axis_tdata;
            r_size_eff <= size_eff;
        end
        r_pos         <= n_pos;
        r_probes      <= n_probes;
        r_res_outcome <= n_res_outcome;
        r_res_slot    <= n_res_slot;
        if (emit) begin
            r_m_outcome <= r_res_outcome;
            r_m_slot    <= r_res_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (emit) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {1'b0, r_m_slot};
    assign m_axis_tuser  = r_m_outcome;

    `LPH_ASSERT_NXT(a_accept_starts_mod, in_accept, act == ACT_MOD)
    `LPH_ASSERT_IMP(a_write_free_slot, st_wr, !rd_used && act == ACT_EVAL)
    `LPH_ASSERT_IMP(a_probe_in_range, act == ACT_READ, 8'(r_pos) < r_size_eff)
    `LPH_ASSERT_IMP(a_miss_slot_zero,
        m_axis_tvalid && (m_axis_tuser == OUT_FULL || m_axis_tuser == OUT_NOT_FOUND),
        m_axis_tdata == 8'd0)

endmodule
`default_nettype wire

### rtl/lph_seq.sv
// Microcode sequencer: step counter, control store and jump conditions.
`default_nettype none
module lph_seq
    import lph_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  t_status i_status,
    output t_act    o_act
);

    t_step r_step;
    t_step n_step;
    t_uop  uop;
    logic  cond_true;

    always_comb begin
        uop = uop_rom(r_step);
        case (uop.cond)
            CND_ALWAYS:     cond_true = 1'b1;
            CND_NO_INPUT:   cond_true = !i_status.in_valid;
            CND_MOD_BUSY:   cond_true = i_status.mod_busy;
            CND_PROBE_MORE: cond_true = i_status.probe_more;
            CND_OUT_BUSY:   cond_true = i_status.out_busy;
            default:        cond_true = 1'b1;
        endcase
        n_step = cond_true ? uop.jmp_t : uop.jmp_f;
        o_act  = uop.act;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule
`default_nettype wire

### rtl/lph_mod.sv
// Iterative signed modulo unit: eight remainder bits per cycle, result made non-negative.
`default_nettype none
module lph_mod
    import lph_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [31:0] i_key,
    input  wire  [7:0]  i_size,
    output logic        o_busy,
    output logic [7:0]  o_rem
);

    logic        r_busy;
    logic [1:0]  r_cnt;
    logic [31:0] r_mag;
    logic [7:0]  r_rem;
    logic [7:0]  r_size;
    logic        r_neg;
    logic [31:0] n_mag;
    logic [7:0]  n_rem;

    always_comb begin
        logic [8:0]  rem;
        logic [31:0] mag;
        rem = {1'b0, r_rem};
        mag = r_mag;
        for (int i = 0; i < MOD_BITS_PER_CYCLE; i++) begin
            rem = {rem[7:0], mag[31]};
            mag = {mag[30:0], 1'b0};
            if (rem >= {1'b0, r_size}) begin
                rem = rem - {1'b0, r_size};
            end
        end
        n_rem = rem[7:0];
        n_mag = mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 2'd1;
            if (r_cnt == MOD_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag  <= i_key[31] ? (32'd0 - i_key) : i_key;
            r_rem  <= '0;
            r_neg  <= i_key[31];
            r_size <= i_size;
        end else if (r_busy) begin
            r_mag <= n_mag;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = (r_neg && (r_rem != 8'd0)) ? (r_size - r_rem) : r_rem;

endmodule
`default_nettype wire

### rtl/lph_store.sv
// Slot store: key memory with registered read and reset-cleared occupied flags.
`default_nettype none
module lph_store #(
    parameter int SLOTS = 128,
    parameter int IW    = 7
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_rd,
    input  wire          i_wr,
    input  wire [IW-1:0] i_addr,
    input  wire [31:0]   i_wkey,
    output logic         o_used,
    output logic [31:0]  o_key
);

    logic [31:0]      mem [SLOTS];
    logic [SLOTS-1:0] r_used;
    logic             r_rd_used;
    logic [31:0]      r_rd_key;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            mem[i_addr] <= i_wkey;
        end
        if (i_rd) begin
            r_rd_key <= mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_wr) begin
            r_used[i_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            r_rd_used <= r_used[i_addr];
        end
    end

    assign o_used = r_rd_used;
    assign o_key  = r_rd_key;

endmodule
`default_nettype wire
